@@ rtl/core/oqhm_pkg.sv @@
// shared types and codes for the ordered queue with hold marks
`timescale 1ns / 1ps

package oqhm_pkg;

   // opcode field of a request word
   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_REMOVE = 3'd3,
      OP_LOCK   = 3'd4,
      OP_UNLOCK = 3'd5,
      OP_GET    = 3'd6,
      OP_NOP    = 3'd7
   } opcode_type;

   // status field of a response word
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SEARCH = 2'd1,
      S_READ   = 2'd2,
      S_APPLY  = 2'd3
   } state_type;

   // command strobes broadcast to every cell
   typedef struct packed {
      logic search;    // evaluate match and register selection
      logic by_id;     // match on id, else on oldest unheld
      logic push;      // write the first empty cell
      logic take;      // cells from the selected one up copy their upper neighbor
      logic set_hold;  // selected cell sets its hold mark
      logic clr_hold;  // selected cell clears its hold mark
   } cell_ctl_type;

   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;

endpackage

@@ rtl/core/ordered_queue_with_hold_marks_core.sv @@
// top level: sequencer, cell chain, counters and response register
//
// Ordered queue of up to DEPTH tagged entries, oldest first. Each request word
// carries an opcode (push, pop, peek, remove, lock, unlock, get), a target id and
// a push word; each request gives exactly one response word with status, id,
// data, the entry count and the count of entries without a hold mark.
// Entries live in a chain of cells; removal shifts the younger cells down by one.
// Timing: a request is taken in idle, then the sequencer steps through search
// along the cell chain, read-out of the selected cell, and apply, which updates
// the queue and loads the response register. The sequencer handles one request
// at a time: a new request is taken only when it is back in idle after apply.
// Stall: the response register holds its word until rsp_tready; a new request
// can be accepted meanwhile, but its apply step waits for the register to free.
// Reset: synchronous; empties the queue, clears hold marks, sets the id counter
// to zero and drops any pending response. No clearing pass is needed.
`timescale 1ns / 1ps

module ordered_queue_with_hold_marks_core #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int ID_WIDTH   = 16,
   localparam int CNT_W     = $clog2(DEPTH + 1),
   localparam int REQ_BITS  = oqhm_pkg::OPCODE_W + ID_WIDTH + DATA_WIDTH,
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = oqhm_pkg::STATUS_W + ID_WIDTH + DATA_WIDTH + 2 * CNT_W,
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // opcode, target_id, push_data (lowest bit up)
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status, result_id, result_data, entry_count, unheld_count (lowest bit up)
   output logic [RSP_W-1:0] rsp_tdata
);
   import oqhm_pkg::*;

   localparam int ID_LO   = OPCODE_W;
   localparam int DATA_LO = OPCODE_W + ID_WIDTH;

   state_type state_ff, state_in;
   cell_ctl_type ctl;
   logic go;

   // latched request
   opcode_type            op_ff, op_in;
   logic [ID_WIDTH-1:0]   tid_ff, tid_in;
   logic [DATA_WIDTH-1:0] pdata_ff, pdata_in;

   // queue bookkeeping
   logic [ID_WIDTH-1:0] idc_ff, idc_in;
   logic [CNT_W-1:0]    ecnt_ff, ecnt_in;
   logic [CNT_W-1:0]    ucnt_ff, ucnt_in;

   // read-out of the selected cell
   logic                  found_ff, found_in;
   logic                  rd_held_ff, rd_held_in;
   logic [ID_WIDTH-1:0]   rd_id_ff, rd_id_in;
   logic [DATA_WIDTH-1:0] rd_data_ff, rd_data_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // cell chain wiring
   logic                  c_valid [DEPTH];
   logic                  c_held  [DEPTH];
   logic [ID_WIDTH-1:0]   c_id    [DEPTH];
   logic [DATA_WIDTH-1:0] c_data  [DEPTH];
   logic                  c_sel   [DEPTH];
   logic                  seen    [DEPTH+1];

   logic full;

   assign full = (ecnt_ff == CNT_W'(DEPTH));
   assign go   = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_SEARCH;
         S_SEARCH: state_in = S_READ;
         S_READ:   state_in = S_APPLY;
         S_APPLY:  if (go) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      ctl          = '0;
      ctl.search   = (state_ff == S_SEARCH);
      ctl.by_id    = !((op_ff == OP_POP) || (op_ff == OP_PEEK));
      if (state_ff == S_APPLY && go) begin
         ctl.push     = (op_ff == OP_PUSH) && !full;
         ctl.take     = found_ff && ((op_ff == OP_POP) || (op_ff == OP_REMOVE));
         ctl.set_hold = found_ff && (op_ff == OP_LOCK);
         ctl.clr_hold = found_ff && (op_ff == OP_UNLOCK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture
   always_comb begin
      op_in    = op_ff;
      tid_in   = tid_ff;
      pdata_in = pdata_ff;
      if (req_tvalid && req_tready) begin
         op_in    = opcode_type'(req_tdata[OPCODE_W-1:0]);
         tid_in   = req_tdata[ID_LO +: ID_WIDTH];
         pdata_in = req_tdata[DATA_LO +: DATA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      tid_ff   <= tid_in;
      pdata_ff <= pdata_in;
   end

   // cell chain
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  prev_v;
      logic                  nv;
      logic                  nh;
      logic [ID_WIDTH-1:0]   nid;
      logic [DATA_WIDTH-1:0] nd;

      if (i == 0) begin : g_first
         assign prev_v = 1'b1;
      end else begin : g_mid
         assign prev_v = c_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign nv  = 1'b0;
         assign nh  = 1'b0;
         assign nid = '0;
         assign nd  = '0;
      end else begin : g_inner
         assign nv  = c_valid[i+1];
         assign nh  = c_held[i+1];
         assign nid = c_id[i+1];
         assign nd  = c_data[i+1];
      end

      oqhm_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .ID_WIDTH   (ID_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .target_id  (tid_ff),
         .push_id    (idc_ff),
         .push_data  (pdata_ff),
         .prev_valid (prev_v),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .nxt_valid  (nv),
         .nxt_held   (nh),
         .nxt_id     (nid),
         .nxt_data   (nd),
         .valid      (c_valid[i]),
         .held       (c_held[i]),
         .id         (c_id[i]),
         .data       (c_data[i]),
         .sel        (c_sel[i])
      );
   end

   // one-hot read-out of the selected cell
   always_comb begin
      found_in   = 1'b0;
      rd_held_in = 1'b0;
      rd_id_in   = '0;
      rd_data_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         found_in   = found_in | c_sel[i];
         rd_held_in = rd_held_in | (c_sel[i] & c_held[i]);
         rd_id_in   = rd_id_in | (c_id[i] & {ID_WIDTH{c_sel[i]}});
         rd_data_in = rd_data_in | (c_data[i] & {DATA_WIDTH{c_sel[i]}});
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         found_ff   <= found_in;
         rd_held_ff <= rd_held_in;
         rd_id_ff   <= rd_id_in;
         rd_data_ff <= rd_data_in;
      end
   end

   // counters and response word
   always_comb begin
      status_type            st;
      logic [ID_WIDTH-1:0]   rid;
      logic [DATA_WIDTH-1:0] rdat;

      idc_in       = idc_ff;
      ecnt_in      = ecnt_ff;
      ucnt_in      = ucnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      st           = ST_OK;
      rid          = '0;
      rdat         = '0;

      unique case (op_ff)
         OP_PUSH: begin
            if (full) begin
               st = ST_FULL;
            end else begin
               rid     = idc_ff;
               idc_in  = idc_ff + 1'b1;
               ecnt_in = ecnt_ff + 1'b1;
               ucnt_in = ucnt_ff + 1'b1;
            end
         end
         OP_POP, OP_PEEK: begin
            if (!found_ff) begin
               st = ST_MISS;
            end else begin
               rid  = rd_id_ff;
               rdat = rd_data_ff;
               if (op_ff == OP_POP) begin
                  ecnt_in = ecnt_ff - 1'b1;
                  ucnt_in = ucnt_ff - 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (!found_ff) begin
               st = ST_MISS;
            end else begin
               rdat    = rd_data_ff;
               ecnt_in = ecnt_ff - 1'b1;
               if (!rd_held_ff) ucnt_in = ucnt_ff - 1'b1;
            end
         end
         OP_LOCK: begin
            if (!found_ff) begin
               st = ST_MISS;
            end else if (!rd_held_ff) begin
               ucnt_in = ucnt_ff - 1'b1;
            end
         end
         OP_UNLOCK: begin
            if (!found_ff) begin
               st = ST_MISS;
            end else if (rd_held_ff) begin
               ucnt_in = ucnt_ff + 1'b1;
            end
         end
         OP_GET: begin
            if (!found_ff) begin
               st = ST_MISS;
            end else begin
               rdat = rd_data_ff;
            end
         end
         OP_NOP: begin
            st = ST_OK;
         end
         default: begin
            st = ST_OK;
         end
      endcase

      if (state_ff == S_APPLY && go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({ucnt_in, ecnt_in, rdat, rid, st});
      end else begin
         idc_in  = idc_ff;
         ecnt_in = ecnt_ff;
         ucnt_in = ucnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idc_ff       <= '0;
         ecnt_ff      <= '0;
         ucnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idc_ff       <= idc_in;
         ecnt_ff      <= ecnt_in;
         ucnt_ff      <= ucnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/core/oqhm_cell.sv @@
// one queue slot: entry storage, local match and neighbor shift
`timescale 1ns / 1ps

module oqhm_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int ID_WIDTH   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  oqhm_pkg::cell_ctl_type ctl,
   input  logic [ID_WIDTH-1:0]    target_id,
   input  logic [ID_WIDTH-1:0]    push_id,
   input  logic [DATA_WIDTH-1:0]  push_data,
   // lower neighbor
   input  logic                   prev_valid,
   input  logic                   seen_in,
   output logic                   seen_out,
   // upper neighbor
   input  logic                   nxt_valid,
   input  logic                   nxt_held,
   input  logic [ID_WIDTH-1:0]    nxt_id,
   input  logic [DATA_WIDTH-1:0]  nxt_data,
   // slot contents
   output logic                   valid,
   output logic                   held,
   output logic [ID_WIDTH-1:0]    id,
   output logic [DATA_WIDTH-1:0]  data,
   output logic                   sel
);
   import oqhm_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  held_ff, held_in;
   logic [ID_WIDTH-1:0]   id_ff, id_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  sel_ff, sel_in;
   logic                  shift_ff, shift_in;
   logic                  hit;

   // local match, oldest-first chain
   always_comb begin
      if (ctl.by_id) begin
         hit = valid_ff && (id_ff == target_id);
      end else begin
         hit = valid_ff && !held_ff;
      end
   end

   assign seen_out = seen_in | hit;

   // selection flags kept for the rest of the operation
   always_comb begin
      sel_in   = sel_ff;
      shift_in = shift_ff;
      if (ctl.search) begin
         sel_in   = hit && !seen_in;
         shift_in = seen_out;
      end
   end

   // slot update
   always_comb begin
      valid_in = valid_ff;
      held_in  = held_ff;
      id_in    = id_ff;
      data_in  = data_ff;
      priority if (ctl.push && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         held_in  = 1'b0;
         id_in    = push_id;
         data_in  = push_data;
      end else if (ctl.take && shift_ff) begin
         valid_in = nxt_valid;
         held_in  = nxt_held;
         id_in    = nxt_id;
         data_in  = nxt_data;
      end else if (ctl.set_hold && sel_ff) begin
         held_in = 1'b1;
      end else if (ctl.clr_hold && sel_ff) begin
         held_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         held_ff  <= 1'b0;
         sel_ff   <= 1'b0;
         shift_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         held_ff  <= held_in;
         sel_ff   <= sel_in;
         shift_ff <= shift_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign held  = held_ff;
   assign id    = id_ff;
   assign data  = data_ff;
   assign sel   = sel_ff;

endmodule

@@ rtl/core/oqhm_checker.sv @@
// port-level checks for the ordered queue, bound to the top level
`timescale 1ns / 1ps

module oqhm_checker #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int ID_WIDTH   = 16,
   localparam int CNT_W     = $clog2(DEPTH + 1),
   localparam int REQ_BITS  = oqhm_pkg::OPCODE_W + ID_WIDTH + DATA_WIDTH,
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = oqhm_pkg::STATUS_W + ID_WIDTH + DATA_WIDTH + 2 * CNT_W,
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);
   import oqhm_pkg::*;

   localparam int ECNT_LO = STATUS_W + ID_WIDTH + DATA_WIDTH;
   localparam int UCNT_LO = ECNT_LO + CNT_W;

   logic [STATUS_W-1:0] st;
   logic [CNT_W-1:0]    ecnt;
   logic [CNT_W-1:0]    ucnt;
   logic                req_seen;

   assign st       = rsp_tdata[STATUS_W-1:0];
   assign ecnt     = rsp_tdata[ECNT_LO +: CNT_W];
   assign ucnt     = rsp_tdata[UCNT_LO +: CNT_W];
   assign req_seen = req_tvalid && req_tready && (req_tdata[0] || !req_tdata[0]);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // one request at a time: no request taken right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_seen |=> !req_tready)
      else $error("request accepted while previous one in flight");

   // counts stay within the queue
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (ecnt <= CNT_W'(DEPTH)) && (ucnt <= ecnt))
      else $error("entry or unheld count out of range");

   // full status only with a full queue
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (st == STATUS_W'(ST_FULL)) |-> ecnt == CNT_W'(DEPTH))
      else $error("full status without a full queue");

endmodule

bind ordered_queue_with_hold_marks_core oqhm_checker #(
   .DEPTH      (DEPTH),
   .DATA_WIDTH (DATA_WIDTH),
   .ID_WIDTH   (ID_WIDTH)
) u_oqhm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ bench/oqhm_reply_checker.sv @@
// checker for the ordered queue: predicts every response word and compares it
`timescale 1ns / 1ps

module oqhm_reply_checker #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int ID_WIDTH   = 16,
   localparam int CNT_W     = $clog2(DEPTH + 1),
   localparam int REQ_W     = ((oqhm_pkg::OPCODE_W + ID_WIDTH + DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W     =
      ((oqhm_pkg::STATUS_W + ID_WIDTH + DATA_WIDTH + 2 * CNT_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   // opcode, target_id, push_data (lowest bit up)
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status, result_id, result_data, entry_count, unheld_count (lowest bit up)
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               pending,
   output int               checked,
   output int               full_seen,
   output int               miss_seen
);
   import oqhm_pkg::*;

   localparam int ID_LO   = STATUS_W;
   localparam int DATA_LO = ID_LO + ID_WIDTH;
   localparam int CNT_LO  = DATA_LO + DATA_WIDTH;

   typedef struct packed {
      status_type            status;
      logic [ID_WIDTH-1:0]   rid;
      logic [DATA_WIDTH-1:0] rdata;
      logic [CNT_W-1:0]      entries;
      logic [CNT_W-1:0]      unheld;
   } reply_type;

   typedef struct {
      logic [ID_WIDTH-1:0]   id;
      logic [DATA_WIDTH-1:0] data;
      logic                  held;
   } entry_type;

   // predicted queue contents, oldest at index zero
   entry_type           slots[$];
   logic [ID_WIDTH-1:0] id_counter;
   reply_type           replies_due[$];

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      full_seen  = 0;
      miss_seen  = 0;
      id_counter = '0;
   end

   // apply one request word to the predicted queue and return its response
   function automatic reply_type predict_reply(opcode_type op, logic [ID_WIDTH-1:0] tid,
                                               logic [DATA_WIDTH-1:0] pdata);
      reply_type r;
      entry_type e;
      int        k;
      int        unheld;
      r        = '0;
      r.status = ST_OK;
      k        = -1;
      case (op)
         OP_PUSH: begin
            if (slots.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               e.id   = id_counter;
               e.data = pdata;
               e.held = 1'b0;
               slots.insert(slots.size(), e);
               r.rid      = id_counter;
               id_counter = id_counter + 1'b1;
            end
         end
         OP_POP, OP_PEEK: begin
            // oldest entry without a hold mark
            for (int i = 0; i < slots.size(); i++) begin
               if (k < 0 && !slots[i].held) k = i;
            end
            if (k < 0) begin
               r.status = ST_MISS;
            end else begin
               r.rid   = slots[k].id;
               r.rdata = slots[k].data;
               if (op == OP_POP) slots.delete(k);
            end
         end
         OP_REMOVE, OP_LOCK, OP_UNLOCK, OP_GET: begin
            // oldest entry with this id wins when ids repeat after a wrap
            for (int i = 0; i < slots.size(); i++) begin
               if (k < 0 && slots[i].id == tid) k = i;
            end
            if (k < 0) begin
               r.status = ST_MISS;
            end else begin
               case (op)
                  OP_REMOVE: begin
                     r.rdata = slots[k].data;
                     slots.delete(k);
                  end
                  OP_LOCK:   slots[k].held = 1'b1;
                  OP_UNLOCK: slots[k].held = 1'b0;
                  default:   r.rdata = slots[k].data;
               endcase
            end
         end
         default: ;
      endcase
      unheld = 0;
      foreach (slots[i]) begin
         if (!slots[i].held) unheld++;
      end
      r.entries = CNT_W'(slots.size());
      r.unheld  = CNT_W'(unheld);
      if (r.status == ST_FULL) full_seen++;
      if (r.status == ST_MISS) miss_seen++;
      return r;
   endfunction

   // watch both channels: compare responses, then predict new requests
   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         slots.delete();
         replies_due.delete();
         id_counter = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status  = status_type'(rsp_tdata[STATUS_W-1:0]);
            got.rid     = rsp_tdata[ID_LO +: ID_WIDTH];
            got.rdata   = rsp_tdata[DATA_LO +: DATA_WIDTH];
            got.entries = rsp_tdata[CNT_LO +: CNT_W];
            got.unheld  = rsp_tdata[CNT_LO + CNT_W +: CNT_W];
            if (replies_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response word with nothing pending: status %0d id %h data %h",
                           $realtime, got.status, got.rid, got.rdata);
            end else begin
               want = replies_due.pop_front();
               checked++;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: expected status %0d id %h data %h entries %0d ",
                               "unheld %0d, got status %0d id %h data %h entries %0d unheld %0d"},
                              $realtime, want.status, want.rid, want.rdata, want.entries,
                              want.unheld, got.status, got.rid, got.rdata, got.entries,
                              got.unheld);
               end
            end
         end
         if (req_tvalid && req_tready)
            replies_due.insert(replies_due.size(),
                               predict_reply(opcode_type'(req_tdata[OPCODE_W-1:0]),
                                             req_tdata[OPCODE_W +: ID_WIDTH],
                                             req_tdata[OPCODE_W + ID_WIDTH +: DATA_WIDTH]));
      end
      pending = replies_due.size();
   end

endmodule

@@ bench/tb_ordered_queue_with_hold_marks_core.sv @@
// testbench top: clock, reset, request stimulus, response back-pressure and verdict
`timescale 1ns / 1ps

module tb_ordered_queue_with_hold_marks_core;
   import oqhm_pkg::*;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int ID_WIDTH    = 16;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int REQ_W       = ((OPCODE_W + ID_WIDTH + DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_W       = ((STATUS_W + ID_WIDTH + DATA_WIDTH + 2 * CNT_W + 7) / 8) * 8;
   localparam int LATENCY     = 3;
   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 3000000;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // opcode, target_id, push_data (lowest bit up)
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // status, result_id, result_data, entry_count, unheld_count (lowest bit up)
   logic [RSP_W-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int checked;
   int full_seen;
   int miss_seen;

   int                  sender_idle_pct  = 0;
   int                  rsp_stall_pct    = 0;
   int                  long_holds_asked = 0;
   int                  long_holds_taken = 0;
   int                  long_hold_left   = 0;
   int                  words_sent       = 0;
   logic [ID_WIDTH-1:0] id_guess         = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ordered_queue_with_hold_marks_core #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ID_WIDTH   (ID_WIDTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   oqhm_reply_checker #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ID_WIDTH   (ID_WIDTH)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .full_seen  (full_seen),
      .miss_seen  (miss_seen)
   );

   // response side: random stalls plus an occasional long hold
   always @(posedge clock) begin
      if (long_hold_left != 0) begin
         rsp_tready     <= 1'b0;
         long_hold_left <= long_hold_left - 1;
      end else if (long_holds_taken != long_holds_asked) begin
         rsp_tready       <= 1'b0;
         long_hold_left   <= LONG_HOLD - 1;
         long_holds_taken <= long_holds_taken + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // offer one request word, with random idle cycles ahead of it
   task automatic send_word(input opcode_type op, input logic [ID_WIDTH-1:0] tid,
                            input logic [DATA_WIDTH-1:0] pdata);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({pdata, tid, op});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_PUSH) id_guess = id_guess + 1'b1;
      words_sent++;
   endtask

   // stop offering and let every predicted response come back
   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // random request word, ids aimed mostly at recently pushed entries
   task automatic send_random_word(input int push_pct);
      opcode_type            op;
      logic [ID_WIDTH-1:0]   tid;
      logic [DATA_WIDTH-1:0] pdata;
      int                    roll;
      roll = $urandom_range(99);
      if (roll < push_pct) begin
         op = OP_PUSH;
      end else begin
         roll = $urandom_range(99);
         if (roll < 25)      op = OP_POP;
         else if (roll < 35) op = OP_PEEK;
         else if (roll < 50) op = OP_REMOVE;
         else if (roll < 66) op = OP_LOCK;
         else if (roll < 82) op = OP_UNLOCK;
         else if (roll < 97) op = OP_GET;
         else                op = OP_NOP;
      end
      if ($urandom_range(9) < 8) tid = id_guess - ID_WIDTH'($urandom_range(1, 18));
      else tid = ID_WIDTH'($urandom);
      case ($urandom_range(15))
         0:       pdata = '0;
         1:       pdata = '1;
         default: pdata = $urandom;
      endcase
      send_word(op, tid, pdata);
   endtask

   // random mix in batches that lean toward filling or draining the queue
   task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
      int push_pct;
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      push_pct        = 45;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0:       push_pct = 15;
               1:       push_pct = 45;
               default: push_pct = 85;
            endcase
         end
         send_random_word(push_pct);
      end
      wait_for_replies();
   endtask

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_ordered_queue_with_hold_marks_core: FAIL");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queue, misses, hold marks, field extremes
      send_word(OP_POP, '0, '0);
      send_word(OP_PEEK, '1, '1);
      send_word(OP_GET, 16'h0000, '0);
      send_word(OP_NOP, '1, '1);
      send_word(OP_PUSH, '0, 32'h0000_0000);
      send_word(OP_PUSH, '1, 32'hFFFF_FFFF);
      send_word(OP_PUSH, 16'h5A5A, 32'h5A5A_C3C3);
      send_word(OP_LOCK, 16'h0000, '0);
      send_word(OP_PEEK, '0, '0);
      send_word(OP_LOCK, 16'h0001, '0);
      send_word(OP_LOCK, 16'h0002, '0);
      // every entry held: pop misses
      send_word(OP_POP, '0, '0);
      send_word(OP_UNLOCK, 16'h0001, '0);
      send_word(OP_GET, 16'h0002, '0);
      send_word(OP_REMOVE, 16'h0002, '1);
      send_word(OP_REMOVE, 16'hFFFF, '0);
      send_word(OP_UNLOCK, 16'hFFFF, '0);
      send_word(OP_LOCK, 16'h1234, '0);
      send_word(OP_POP, '0, '0);
      send_word(OP_POP, '0, '0);
      send_word(OP_PEEK, '0, '0);
      send_word(OP_PUSH, '1, 32'h8000_0001);
      wait_for_replies();

      // entry 0 is still held at the head: by-id access to it, then it leaves
      send_word(OP_PUSH, '0, 32'hC0DE_0000);
      send_word(OP_GET, 16'h0000, '0);
      send_word(OP_LOCK, 16'h0000, '0);
      send_word(OP_REMOVE, 16'h0000, '0);
      send_word(OP_GET, 16'h0000, '0);
      send_word(OP_LOCK, 16'h0000, '0);
      send_word(OP_PEEK, '0, '0);
      wait_for_replies();

      run_random_phase(150, 0, 0);
      run_random_phase(150, 75, 0);
      run_random_phase(150, 0, 75);
      run_random_phase(150, 26, 26);

      // long response hold while requests keep coming, then a full pause
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      long_holds_asked++;
      repeat (24) send_random_word(60);
      wait_for_replies();
      repeat (16) send_random_word(60);
      wait_for_replies();

      repeat (10 * LATENCY) @(posedge clock);
      $display("sent %0d request words: directed cases, by-id access to a held head entry,",
               words_sent);
      $display("random mixes under four idle modes and a long hold; %0d checked, %0d full, %0d miss",
               checked, full_seen, miss_seen);
      if (fail_count == 0 && pending == 0)
         $display("tb_ordered_queue_with_hold_marks_core: PASS");
      else
         $display("tb_ordered_queue_with_hold_marks_core: FAIL");
      $finish;
   end

endmodule
